FILE: sv/pffa_pkg.sv
// pffa_pkg: shared sizes, codes and control structs for the page-fault frame allocator.
// No dependencies; imported by every module of the block.
package pffa_pkg;

  localparam int MAX_PAGES  = 64;
  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int NPAGE_W    = PAGE_W + 1;   // page count register, holds MAX_PAGES
  localparam int NFRAME_W   = FRAME_W + 1;  // frame count register, holds MAX_FRAMES
  localparam int LFSR_W     = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = LFSR_W / 2;   // two remainder bits per cycle
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGES  = 2'd0,
    CFG_FRAMES = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_EVICT    = 2'd1,
    ST_RESIDENT = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DIVIDE,
    S_OWNER,
    S_EVICT,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;      // latch request, start page table read
    logic classify;     // decide range / resident / free / evict
    logic div_step;     // one modulo iteration
    logic victim_read;  // latch victim frame, read its owner
    logic evict;        // unmap old owner
    logic commit;       // write tables and counter
    logic publish;      // load output word
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic resident;
    logic free_found;
    logic div_done;
  } dp_status_t;

endpackage

FILE: sv/pffa_ctrl.sv
// pffa_ctrl: sequencing state machine and output valid flag.
// Depends on pffa_pkg; drives commands into pffa_dp.
module pffa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pffa_pkg::dp_status_t  sts,
  output pffa_pkg::ctrl_cmd_t   cmd
);
  import pffa_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_LOOKUP;
      S_LOOKUP: begin
        if (sts.out_of_range || sts.resident) state_next = S_DONE;
        else if (sts.free_found)              state_next = S_COMMIT;
        else                                  state_next = S_DIVIDE;
      end
      S_DIVIDE: if (sts.div_done) state_next = S_OWNER;
      S_OWNER:  state_next = S_EVICT;
      S_EVICT:  state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOOKUP: cmd.classify    = 1'b1;
      S_DIVIDE: cmd.div_step    = 1'b1;
      S_OWNER:  cmd.victim_read = 1'b1;
      S_EVICT:  cmd.evict       = 1'b1;
      S_COMMIT: cmd.commit      = 1'b1;
      S_DONE:   cmd.publish     = out_free;
      default:  cmd             = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish)     out_valid_next = 1'b1;
    else if (out_ready)  out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/pffa_dp.sv
// pffa_dp: page/frame tables, config registers, LFSR, modulo unit and result registers.
// Depends on pffa_pkg; steered by pffa_ctrl commands.
module pffa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pffa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [pffa_pkg::PAGE_W-1:0]        requested_page,
  input  pffa_pkg::ctrl_cmd_t                cmd,
  output pffa_pkg::dp_status_t               sts,
  output logic [1:0]                         status,
  output logic [pffa_pkg::FRAME_W-1:0]       assigned_frame,
  output logic                               evicted_valid,
  output logic [pffa_pkg::PAGE_W-1:0]        evicted_page,
  output logic [pffa_pkg::CNT_W-1:0]         disk_accesses
);
  import pffa_pkg::*;

  // config
  logic [NPAGE_W-1:0]  pages_cfg;
  logic [NFRAME_W-1:0] frames_cfg;
  logic [NPAGE_W-1:0]  np;
  logic [NFRAME_W-1:0] nf;

  // tables
  logic [MAX_PAGES-1:0]  page_valid;
  logic [MAX_FRAMES-1:0] frame_used;
  logic [FRAME_W-1:0]    page_frame_mem [MAX_PAGES];
  logic [PAGE_W-1:0]     owner_mem [MAX_FRAMES];
  logic [FRAME_W-1:0]    pf_rdata;
  logic [PAGE_W-1:0]     owner_rdata;

  logic [LFSR_W-1:0]     lfsr;
  logic [LFSR_W-1:0]     lfsr_adv;
  logic [CNT_W-1:0]      load_count;

  // modulo unit
  logic [LFSR_W-1:0]     div_word;
  logic [FRAME_W-1:0]    rem;
  logic [DIV_CNT_W-1:0]  div_cnt;

  // request / result
  logic [PAGE_W-1:0]     page;
  status_t               res_status;
  logic [FRAME_W-1:0]    res_frame;
  logic                  res_ev_valid;
  logic [PAGE_W-1:0]     res_ev_page;

  logic                  free_found;
  logic [FRAME_W-1:0]    free_idx;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

  // restoring step: remainder stays below the divisor, so FRAME_W bits hold it
  function automatic logic [FRAME_W-1:0] mod_step(input logic [FRAME_W-1:0] r,
                                                  input logic b,
                                                  input logic [NFRAME_W-1:0] d);
    logic [NFRAME_W-1:0] t;
    t = {r, b};
    if (t >= d) t = t - d;
    return t[FRAME_W-1:0];
  endfunction

  // clamp counts: pages above max act as max; frames above max as max, zero as one
  always_comb begin
    np = (pages_cfg > NPAGE_W'(MAX_PAGES)) ? NPAGE_W'(MAX_PAGES) : pages_cfg;
    if (frames_cfg > NFRAME_W'(MAX_FRAMES)) nf = NFRAME_W'(MAX_FRAMES);
    else if (frames_cfg == '0)              nf = NFRAME_W'(1);
    else                                    nf = frames_cfg;
  end

  // lowest free frame below nf
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((NFRAME_W'(i) < nf) && !frame_used[i]) begin
        free_found = 1'b1;
        free_idx   = FRAME_W'(i);
      end
    end
  end

  assign lfsr_adv = lfsr_next(lfsr);

  assign sts.out_of_range = {1'b0, page} >= np;
  assign sts.resident     = page_valid[page];
  assign sts.free_found   = free_found;
  assign sts.div_done     = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.capture) pf_rdata <= page_frame_mem[requested_page];
    if (cmd.commit)  page_frame_mem[page] <= res_frame;
  end

  always_ff @(posedge clk) begin
    if (cmd.victim_read) owner_rdata <= owner_mem[rem];
    if (cmd.commit)      owner_mem[res_frame] <= page;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_cfg  <= NPAGE_W'(MAX_PAGES);
      frames_cfg <= NFRAME_W'(MAX_FRAMES);
      lfsr       <= LFSR_W'(1);
      load_count <= '0;
      page_valid <= '0;
      frame_used <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGES:  pages_cfg  <= cfg_data[NPAGE_W-1:0];
          CFG_FRAMES: frames_cfg <= cfg_data[NFRAME_W-1:0];
          CFG_SEED:   lfsr       <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
          default:    ;
        endcase
      end
      if (cmd.classify && !sts.out_of_range && !sts.resident && !free_found)
        lfsr <= lfsr_adv;
      if (cmd.evict) page_valid[owner_rdata] <= 1'b0;
      if (cmd.commit) begin
        page_valid[page]      <= 1'b1;
        frame_used[res_frame] <= 1'b1;
        if (load_count != '1) load_count <= load_count + CNT_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) page <= requested_page;

    if (cmd.classify) begin
      res_ev_valid <= 1'b0;
      res_ev_page  <= '0;
      div_word     <= lfsr_adv;
      rem          <= '0;
      div_cnt      <= '0;
      if (sts.out_of_range) begin
        res_status <= ST_RANGE;
        res_frame  <= '0;
      end else if (sts.resident) begin
        res_status <= ST_RESIDENT;
        res_frame  <= pf_rdata;
      end else if (free_found) begin
        res_status <= ST_FREE;
        res_frame  <= free_idx;
      end else begin
        res_status <= ST_EVICT;
        res_frame  <= '0;
      end
    end

    if (cmd.div_step) begin
      rem      <= mod_step(mod_step(rem, div_word[LFSR_W-1], nf), div_word[LFSR_W-2], nf);
      div_word <= {div_word[LFSR_W-3:0], 2'b00};
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
    end

    if (cmd.victim_read) res_frame <= rem;

    if (cmd.evict) begin
      res_ev_valid <= 1'b1;
      res_ev_page  <= owner_rdata;
    end

    if (cmd.publish) begin
      status         <= res_status;
      assigned_frame <= res_frame;
      evicted_valid  <= res_ev_valid;
      evicted_page   <= res_ev_page;
      disk_accesses  <= load_count;
    end
  end

endmodule

FILE: sv/page_fault_frame_allocator.sv
// page_fault_frame_allocator: top level, demand paging with random replacement.
// Depends on pffa_pkg, pffa_ctrl, pffa_dp.
//
//  channel  handshake              word
//  -------  ---------------------  ------------------------------------------------
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (0 pages, 1 frames, 2 seed)
//  in       in_valid / in_ready    requested_page
//  out      out_valid / out_ready  status, assigned_frame, evicted_valid,
//                                  evicted_page, disk_accesses
//
// The result word is loaded as the block returns to idle. The eviction path
// runs through the modulo unit, which retires two remainder bits of the
// 16-bit LFSR value per cycle.
// One request is in flight at a time; in_ready is high only while idle.
// The output word sits in its own register, so a new request is taken while
// an earlier result waits; a second result stalls until the first is taken.
// Reset (sync, active high) clears all valid/used bits at once, no sweep.
// cfg_ready is always high; writes are expected only while the block is idle.
module page_fault_frame_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pffa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pffa_pkg::PAGE_W-1:0]        requested_page,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [pffa_pkg::FRAME_W-1:0]       assigned_frame,
  output logic                               evicted_valid,
  output logic [pffa_pkg::PAGE_W-1:0]        evicted_page,
  output logic [pffa_pkg::CNT_W-1:0]         disk_accesses
);
  import pffa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // config registers always accept
  assign cfg_ready = 1'b1;

  pffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pffa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .requested_page (requested_page),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status),
    .assigned_frame (assigned_frame),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .disk_accesses  (disk_accesses)
  );

endmodule

FILE: sv/pffa_checker.sv
// pffa_checker: port-level assertions for page_fault_frame_allocator, bound to the top.
// Depends on pffa_pkg.
module pffa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         status,
  input logic [pffa_pkg::FRAME_W-1:0]       assigned_frame,
  input logic                               evicted_valid,
  input logic [pffa_pkg::PAGE_W-1:0]        evicted_page,
  input logic [pffa_pkg::CNT_W-1:0]         disk_accesses
);
  import pffa_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(assigned_frame)
      && $stable(evicted_valid) && $stable(evicted_page) && $stable(disk_accesses))
    else $error("result word changed while stalled");

  // one request at a time: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another in flight");

  // eviction reported only with eviction status
  a_evict_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> status == ST_EVICT)
    else $error("evicted_valid without eviction status");

  // out-of-range result carries no frame and no eviction
  a_range_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> assigned_frame == '0 && !evicted_valid)
    else $error("out-of-range result has nonzero fields");

endmodule

bind page_fault_frame_allocator pffa_checker u_pffa_checker (.*);

FILE: dv/pffa_reply_checker.sv
// pffa_reply_checker: watches the config, request and result channels of the allocator,
// keeps its own copy of the page and frame tables and checks every result word.
// Depends on pffa_pkg only.
module pffa_reply_checker
  import pffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PAGE_W-1:0]     requested_page,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            status,
  input  logic [FRAME_W-1:0]    assigned_frame,
  input  logic                  evicted_valid,
  input  logic [PAGE_W-1:0]     evicted_page,
  input  logic [CNT_W-1:0]      disk_accesses,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            st;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [CNT_W-1:0]   loads;
  } fault_reply_t;

  fault_reply_t replies_due[$];

  logic                pg_mapped [MAX_PAGES];
  logic [FRAME_W-1:0]  pg_frame  [MAX_PAGES];
  logic                frm_busy  [MAX_FRAMES];
  logic [PAGE_W-1:0]   frm_owner [MAX_FRAMES];
  logic [LFSR_W-1:0]   victim_lfsr;
  logic [CNT_W-1:0]    load_tally;
  logic [NPAGE_W-1:0]  page_limit;
  logic [NFRAME_W-1:0] frame_limit;

  initial begin
    fails   = 0;
    pending = 0;
  end

  // Serves one fault against the shadow tables and returns the word it should produce.
  function automatic fault_reply_t serve_fault(input logic [PAGE_W-1:0] pg);
    fault_reply_t r;
    int np, nf, slot, f;
    np = (page_limit > MAX_PAGES) ? MAX_PAGES : int'(page_limit);
    nf = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    if (nf == 0) nf = 1;
    r = '0;
    slot = -1;
    if (int'(pg) >= np) begin
      r.st = ST_RANGE;
    end else if (pg_mapped[pg]) begin
      r.st    = ST_RESIDENT;
      r.frame = pg_frame[pg];
    end else begin
      for (f = 0; f < nf; f++)
        if (slot < 0 && !frm_busy[f]) slot = f;
      if (slot >= 0) begin
        r.st = ST_FREE;
      end else begin
        // all searchable frames busy: step the LFSR, then pick the victim
        victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                       victim_lfsr[LFSR_W-1:1]};
        slot = int'(victim_lfsr) % nf;
        r.st       = ST_EVICT;
        r.ev_valid = 1'b1;
        r.ev_page  = frm_owner[slot];
        pg_mapped[frm_owner[slot]] = 1'b0;
      end
      r.frame         = slot[FRAME_W-1:0];
      frm_busy[slot]  = 1'b1;
      frm_owner[slot] = pg;
      pg_mapped[pg]   = 1'b1;
      pg_frame[pg]    = slot[FRAME_W-1:0];
      if (load_tally != '1) load_tally = load_tally + CNT_W'(1);
    end
    r.loads = load_tally;
    return r;
  endfunction

  task automatic note_field(input string what, input logic [CNT_W-1:0] want_v,
                            input logic [CNT_W-1:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    fault_reply_t want;
    int i;
    if (rst) begin
      replies_due.delete();
      for (i = 0; i < MAX_PAGES; i++) pg_mapped[i] = 1'b0;
      for (i = 0; i < MAX_FRAMES; i++) frm_busy[i] = 1'b0;
      victim_lfsr = LFSR_W'(1);
      load_tally  = '0;
      page_limit  = NPAGE_W'(MAX_PAGES);
      frame_limit = NFRAME_W'(MAX_FRAMES);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGES:  page_limit  = cfg_data[NPAGE_W-1:0];
          CFG_FRAMES: frame_limit = cfg_data[NFRAME_W-1:0];
          CFG_SEED:   victim_lfsr = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
          default: ;
        endcase
      end
      // result side first: a word leaving now never belongs to a request taken now
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          fails++;
          $display("%0t: result word expected none, got status %0d frame %0d evicted %0d/%0d count %0d",
                   $time, status, assigned_frame, evicted_valid, evicted_page, disk_accesses);
        end else begin
          want = replies_due.pop_front();
          note_field("status", CNT_W'(want.st), CNT_W'(status));
          note_field("assigned_frame", CNT_W'(want.frame), CNT_W'(assigned_frame));
          note_field("evicted_valid", CNT_W'(want.ev_valid), CNT_W'(evicted_valid));
          note_field("evicted_page", CNT_W'(want.ev_page), CNT_W'(evicted_page));
          note_field("disk_accesses", want.loads, disk_accesses);
        end
      end
      if (in_valid && in_ready) replies_due.push_back(serve_fault(requested_page));
    end
    pending <= replies_due.size();
  end

endmodule

FILE: dv/tb_page_fault_frame_allocator.sv
// tb_page_fault_frame_allocator: stimulus and verdict for the page-fault frame allocator.
// Depends on pffa_pkg, page_fault_frame_allocator and pffa_reply_checker.
// Directed faults first, then random phases under changing idle mixes.
module tb_page_fault_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pffa_pkg::*;

  // register index the block does not decode; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 24;       // covers the longest request (eviction), plus margin
  localparam int RUN_LIMIT     = 200000;   // hang guard bound for the full run
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 150;

  logic                  clk;
  logic                  rst            = 1'b1;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [PAGE_W-1:0]     requested_page = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [1:0]            status;
  logic [FRAME_W-1:0]    assigned_frame;
  logic                  evicted_valid;
  logic [PAGE_W-1:0]     evicted_page;
  logic [CNT_W-1:0]      disk_accesses;

  int          fails;
  int          pending;
  int          send_idle = 9;   // percent of cycles the request side holds back
  int          recv_idle = 67;  // percent of cycles the result side stalls
  int unsigned cycles    = 0;

  page_fault_frame_allocator uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .requested_page (requested_page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .assigned_frame (assigned_frame),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .disk_accesses  (disk_accesses)
  );

  pffa_reply_checker reply_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .requested_page (requested_page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .assigned_frame (assigned_frame),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .disk_accesses  (disk_accesses),
    .fails          (fails),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("tb_page_fault_frame_allocator failed");
      $finish;
    end
  end

  // result side: stall at random, never when recv_idle is zero
  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_idle);

  // Presents one request word and returns at the edge it is taken. Valid is not
  // dropped here, so back-to-back words keep it high without a glitch.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    requested_page <= pg;
    do @(posedge clk); while (!in_ready);
  endtask

  // Same idea for the config channel; the caller drops cfg_valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pages,
                           input logic [CFG_DATA_W-1:0] frames,
                           input logic [CFG_DATA_W-1:0] seed);
    write_reg(CFG_PAGES, pages);
    write_reg(CFG_FRAMES, frames);
    write_reg(CFG_SEED, seed);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait until every expected word is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: fresh settings, then mostly in-range faults with some strays.
  task automatic run_phase(input int count, input int pause_at);
    logic [CFG_DATA_W-1:0] pages_w, frames_w;
    logic [PAGE_W-1:0]     pg;
    int                    span, k;
    if ($urandom_range(0, 3) == 0) pages_w = CFG_DATA_W'($urandom_range(65, 127));  // clamps
    else pages_w = CFG_DATA_W'($urandom_range(1, 64));
    case ($urandom_range(0, 3))
      0:       frames_w = CFG_DATA_W'($urandom_range(1, 16));
      1:       frames_w = CFG_DATA_W'($urandom_range(0, 31));   // zero and oversize included
      default: frames_w = CFG_DATA_W'(MAX_FRAMES);
    endcase
    span = (pages_w > MAX_PAGES) ? MAX_PAGES : int'(pages_w);
    drain();
    configure(pages_w, frames_w, CFG_DATA_W'($urandom_range(0, 65535)));
    for (k = 0; k < count; k++) begin
      if (k == pause_at) drain();   // hold off until the block is empty
      if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
      else pg = PAGE_W'($urandom_range(0, span - 1));
      send_page(pg);
    end
  endtask

  initial begin : stimulus
    int p;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // Undecoded index, then full sizes with a zero seed (acts as one).
    // First-time faults fill frames from the bottom; a repeat of page 0 is resident.
    write_reg(CFG_NONE, 16'hFFFF);
    configure(16'd64, 16'd16, 16'h0000);
    send_page(0);
    send_page(63);
    send_page(0);
    send_page(5);
    send_page(21);
    send_page(42);
    drain();
    // page count masks to zero: everything out of range; frame count zero acts as one
    configure(16'hFF80, 16'hFFE0, 16'hFFFF);
    send_page(0);
    send_page(63);
    drain();
    // one page: page 0 still resident, page 1 out of range
    configure(16'd1, 16'd1, 16'hACE1);
    send_page(0);
    send_page(1);
    drain();
    // oversize page count, frame count zero: every miss evicts from frame 0 only,
    // page 63 stays resident in a frame above the count
    configure(16'd127, 16'd0, 16'hACE1);
    send_page(9);
    send_page(33);
    send_page(63);
    send_page(0);
    drain();
    // shrink pages to 8 over five frames: pages above the count may be evicted
    configure(16'd8, 16'd5, 16'h8000);
    send_page(1);
    send_page(2);
    send_page(3);
    send_page(4);
    send_page(5);
    drain();
    // grow back to full size: free frames above the old count get used
    configure(16'd64, 16'd31, 16'hFFFF);
    send_page(60);
    send_page(61);

    // --- random phases: idle mixes change every few phases ---
    for (p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle = 9;
        recv_idle = 67;
      end else if (p < 6) begin
        send_idle = 67;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_phase(PHASE_WORDS, (p == 1) ? PHASE_WORDS / 2 : -1);
    end

    drain();
    if (fails == 0) begin
      $display("tb_page_fault_frame_allocator passed");
    end else begin
      $display("tb_page_fault_frame_allocator failed");
    end
    $finish;
  end

endmodule
